// ===== hw/rtl/pcwc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcwc_pkg
// Types, register indexes and helpers shared by the charge window colorizer.
// ----------------------------------------------------------------------------
package pcwc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;
  localparam int unsigned NUM_W       = 44;
  localparam int unsigned DIV_CNT_W   = 6;
  localparam logic [19:0] ACC_MAX     = 20'hFFFFF;

  typedef enum logic [2:0] {
    REG_TIME_CENTER = 3'd0,
    REG_TIME_WIDTH  = 3'd1,
    REG_SHOW_MAX    = 3'd2,
    REG_MAX_VALUE   = 3'd3,
    REG_THRESHOLD   = 3'd4,
    REG_BAND_SCALE  = 3'd5,
    REG_LOW_COLOR   = 3'd6,
    REG_HIGH_COLOR  = 3'd7
  } reg_index_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_LERP = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [9:0]  time_center;
    logic [9:0]  time_width;
    logic        show_max;
    logic [19:0] max_value;
    logic [19:0] threshold;
    logic [15:0] band_scale;
    logic [31:0] low_color;
    logic [31:0] high_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0] col_offset;
    logic [6:0] row_index;
    logic [9:0] sample_value;
    logic [7:0] pad_index;
    logic [9:0] time_bin;
  } sample_t;

  typedef struct packed {
    logic [19:0] pad_result;
    logic [7:0]  pixel_col;
    logic [6:0]  pixel_row;
  } pix_job_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] mark_fraction;
    logic [19:0] pad_result;
    logic [7:0]  pixel_col;
    logic [6:0]  pixel_row;
  } pixel_t;

  // Reduce a value below 512 modulo m by shifted compare and subtract.
  function automatic logic [9:0] mod_wrap(input logic [9:0] v, input logic [10:0] m);
    logic [16:0] acc;
    logic [16:0] sh;
    acc = {7'd0, v};
    for (int k = 6; k >= 0; k--) begin
      sh = {6'd0, m} << k;
      if (acc >= sh) begin
        acc = acc - sh;
      end
    end
    return acc[9:0];
  endfunction

endpackage

// ===== hw/rtl/pad_charge_window_colorizer_top.sv =====
// Flow: a pad's last sample is written into the pixel queue at its accepting edge;
//   the back part then pops it, multiplies, runs 44 restoring division steps and
//   interpolates into the output register once that register is free.
// Throughput: one sample per cycle while the four-entry pixel queue has room; the
//   serial band mark divider in the back part takes a new pixel only when done with the last.
// Reset: asynchronous, active low; clears the accumulator, queue and sequencer and
//   loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// pad_charge_window_colorizer_top
// Pad charge integration or maximum with threshold, color band mark and RGBA interpolation.
// ----------------------------------------------------------------------------
module pad_charge_window_colorizer_top #(
  parameter int unsigned IMAGE_WIDTH  = 256,
  parameter int unsigned IMAGE_HEIGHT = 128,
  parameter int unsigned ADC_BITS     = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // time_bin[9:0], pad_index[17:10], sample_value[27:18], row_index[34:28],
  // col_offset[42:35], zero fill above
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_row[6:0], pixel_col[14:7], pad_result[34:15], mark_fraction[50:35],
  // red[58:51], green[66:59], blue[74:67], alpha[82:75], zero fill above
  output logic [87:0] m_axis_tdata
);
  import pcwc_pkg::*;

  cfg_t       cfg_q;
  sample_t    sample;
  pix_job_t   push_job, pop_job;
  logic       q_push, q_pop, q_full, q_empty;
  pixel_t     pixel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_center <= 10'd500;
      cfg_q.time_width  <= 10'd10;
      cfg_q.show_max    <= 1'b0;
      cfg_q.max_value   <= 20'd128;
      cfg_q.threshold   <= 20'd5;
      cfg_q.band_scale  <= 16'd256;
      cfg_q.low_color   <= 32'h0000_0000;
      cfg_q.high_color  <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_addr_i))
        REG_TIME_CENTER: cfg_q.time_center <= cfg_wdata_i[9:0];
        REG_TIME_WIDTH:  cfg_q.time_width  <= cfg_wdata_i[9:0];
        REG_SHOW_MAX:    cfg_q.show_max    <= cfg_wdata_i[0];
        REG_MAX_VALUE:   cfg_q.max_value   <= cfg_wdata_i[19:0];
        REG_THRESHOLD:   cfg_q.threshold   <= cfg_wdata_i[19:0];
        REG_BAND_SCALE:  cfg_q.band_scale  <= cfg_wdata_i[15:0];
        REG_LOW_COLOR:   cfg_q.low_color   <= cfg_wdata_i;
        REG_HIGH_COLOR:  cfg_q.high_color  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sample = s_axis_tdata[42:0];

  pcwc_front #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .ADC_BITS    (ADC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .sample_i(sample),
    .last_i  (s_axis_tlast),
    .full_i  (q_full),
    .push_o  (q_push),
    .job_o   (push_job)
  );

  pcwc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(push_job),
    .pop_i  (q_pop),
    .rdata_o(pop_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  pcwc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .empty_i(q_empty),
    .job_i  (pop_job),
    .pop_o  (q_pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .pixel_o(pixel)
  );

  assign m_axis_tdata = {5'd0, pixel};

endmodule

// ===== hw/rtl/pcwc_front.sv =====
// ----------------------------------------------------------------------------
// pcwc_front
// Per-pad window integration or maximum, clamp and threshold; queues pixels.
// ----------------------------------------------------------------------------
module pcwc_front #(
  parameter int unsigned IMAGE_WIDTH  = 256,
  parameter int unsigned IMAGE_HEIGHT = 128,
  parameter int unsigned ADC_BITS     = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcwc_pkg::cfg_t    cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  pcwc_pkg::sample_t sample_i,
  input  logic              last_i,
  input  logic              full_i,
  output logic              push_o,
  output pcwc_pkg::pix_job_t job_o
);
  import pcwc_pkg::*;

  localparam logic [9:0] ADC_MASK = (ADC_BITS >= 10) ? 10'h3FF : 10'((1 << ADC_BITS) - 1);

  logic [19:0]        acc_q, acc_d, acc_new;
  logic [9:0]         val;
  logic signed [11:0] lo_t, hi_t, t_s;
  logic               in_win, border, halve;
  logic [9:0]         add;
  logic [20:0]        sum;
  logic [19:0]        res;
  logic               take;
  logic [9:0]         col_sum;
  logic [9:0]         col_wrap;
  logic [9:0]         row_wrap;

  assign ready_o = ~full_i;
  assign take    = valid_i & ready_o;
  assign val     = sample_i.sample_value & ADC_MASK;

  assign t_s    = $signed({2'b00, sample_i.time_bin});
  assign lo_t   = $signed({2'b00, cfg_i.time_center}) - $signed({3'b000, cfg_i.time_width[9:1]});
  assign hi_t   = $signed({2'b00, cfg_i.time_center}) + $signed({3'b000, cfg_i.time_width[9:1]});
  assign halve  = ~cfg_i.time_width[0];
  assign in_win = (t_s >= lo_t) && (t_s <= hi_t);
  assign border = (t_s == lo_t) || (t_s == hi_t);
  assign add    = (halve && border) ? {1'b0, val[9:1]} : val;
  assign sum    = {1'b0, acc_q} + {11'd0, add};

  always_comb begin
    acc_new = acc_q;
    if (cfg_i.show_max) begin
      if ({10'd0, val} > acc_q) begin
        acc_new = {10'd0, val};
      end
    end else if (in_win) begin
      acc_new = sum[20] ? ACC_MAX : sum[19:0];
    end
  end

  assign res   = (acc_new < cfg_i.max_value) ? acc_new : cfg_i.max_value;
  assign acc_d = take ? (last_i ? 20'd0 : acc_new) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 20'd0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign col_sum  = {2'b00, sample_i.pad_index} + {2'b00, sample_i.col_offset};
  assign col_wrap = mod_wrap(col_sum, 11'(IMAGE_WIDTH));
  assign row_wrap = mod_wrap({3'b000, sample_i.row_index}, 11'(IMAGE_HEIGHT));

  assign push_o           = take & last_i & (res > cfg_i.threshold);
  assign job_o.pad_result = res;
  assign job_o.pixel_col  = col_wrap[7:0];
  assign job_o.pixel_row  = row_wrap[6:0];

endmodule

// ===== hw/rtl/pcwc_queue.sv =====
// ----------------------------------------------------------------------------
// pcwc_queue
// Short pixel job queue between the front and back parts.
// ----------------------------------------------------------------------------
module pcwc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcwc_pkg::pix_job_t wdata_i,
  input  logic               pop_i,
  output pcwc_pkg::pix_job_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);
  import pcwc_pkg::*;

  pix_job_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != QCNT_W'(QUEUE_DEPTH)) |-> wptr_q != rptr_q)
    else $error("pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/pcwc_back.sv =====
// ----------------------------------------------------------------------------
// pcwc_back
// Band mark by serial division and RGBA interpolation into the output stage.
// ----------------------------------------------------------------------------
module pcwc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcwc_pkg::cfg_t      cfg_i,
  input  logic                empty_i,
  input  pcwc_pkg::pix_job_t  job_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output pcwc_pkg::pixel_t    pixel_o
);
  import pcwc_pkg::*;

  back_state_e          state_q, state_d;
  pix_job_t             job_q;
  logic [19:0]          diff_q, den_q;
  logic [NUM_W-1:0]     num_q;
  logic [19:0]          rem_q;
  logic [15:0]          quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 out_valid_q;
  pixel_t               out_q;
  logic [21:0]          trial;
  logic                 load_out;
  logic [15:0]          mark;
  logic [35:0]          prod;

  function automatic logic [7:0] lerp8(input logic [7:0] lo, input logic [7:0] hi,
                                       input logic [15:0] m);
    logic signed [8:0]  d;
    logic signed [16:0] mm;
    logic signed [25:0] p;
    logic [10:0]        s;
    d  = $signed({1'b0, hi}) - $signed({1'b0, lo});
    mm = $signed({1'b0, m});
    p  = d * mm;
    s  = {3'b000, lo} + {p[25], p[25:16]};
    return s[7:0];
  endfunction

  assign trial = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
  assign prod  = diff_q * cfg_i.band_scale;
  assign mark  = (den_q == 20'd0) ? 16'd0 : quo_q;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_MUL: state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
          state_d = BK_LERP;
        end
      end
      BK_LERP: begin
        if (!out_valid_q || ready_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        job_q  <= job_i;
        diff_q <= job_i.pad_result - cfg_i.threshold;
        den_q  <= cfg_i.max_value - cfg_i.threshold;
      end
      BK_MUL: begin
        num_q <= {prod, 8'd0};
        rem_q <= '0;
        quo_q <= '0;
      end
      BK_DIV: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        if (!trial[21]) begin
          rem_q <= trial[19:0];
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= {rem_q[18:0], num_q[NUM_W-1]};
          quo_q <= {quo_q[14:0], 1'b0};
        end
      end
      BK_LERP: begin
        if (load_out) begin
          out_q.pixel_row     <= job_q.pixel_row;
          out_q.pixel_col     <= job_q.pixel_col;
          out_q.pad_result    <= job_q.pad_result;
          out_q.mark_fraction <= mark;
          out_q.red   <= lerp8(cfg_i.low_color[31:24], cfg_i.high_color[31:24], mark);
          out_q.green <= lerp8(cfg_i.low_color[23:16], cfg_i.high_color[23:16], mark);
          out_q.blue  <= lerp8(cfg_i.low_color[15:8], cfg_i.high_color[15:8], mark);
          out_q.alpha <= lerp8(cfg_i.low_color[7:0], cfg_i.high_color[7:0], mark);
        end
      end
      default: ;
    endcase
  end

  assign valid_o = out_valid_q;
  assign pixel_o = out_q;

endmodule

// ===== tb/sv/pcwc_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// pcwc_pixel_checker
// Watches the register port and both stream channels of the charge window
// colorizer. Tracks its own register copy and pad charge, predicts each
// emitted pixel, and compares every output transfer field by field in order.
// ----------------------------------------------------------------------------
module pcwc_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic        drain_i,
  output int          fail_count_o,
  output int          pending_o
);
  import pcwc_pkg::*;

  localparam int PRINT_LIMIT = 40;

  localparam cfg_t CFG_RESET = '{
    time_center: 10'd500,
    time_width:  10'd10,
    show_max:    1'b0,
    max_value:   20'd128,
    threshold:   20'd5,
    band_scale:  16'd256,
    low_color:   32'h0000_0000,
    high_color:  32'hFFFF_FFFF
  };

  cfg_t        cfg_q;
  logic [19:0] charge_q;
  pixel_t      pending_pixels[$];
  int          errors = 0;
  bit          drained;

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) begin
      $display("%0t: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic logic [7:0] blend_channel(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [15:0] m);
    logic [31:0] v;
    v = 32'(lo) * (32'd65536 - 32'(m)) + 32'(hi) * 32'(m);
    return v[23:16];
  endfunction

  // Add one sample to the pad charge; on the pad's last sample queue the pixel if its result exceeds the threshold
  task automatic integrate_sample(input sample_t s, input logic last);
    int          t;
    int          half;
    int          lo_t;
    int          hi_t;
    logic [9:0]  add;
    logic [20:0] sum;
    logic [19:0] res;
    logic [19:0] den;
    logic [63:0] num;
    logic [15:0] mark;
    pixel_t      px;
    t = int'(s.time_bin);
    if (cfg_q.show_max) begin
      if (20'(s.sample_value) > charge_q) begin
        charge_q = 20'(s.sample_value);
      end
    end else begin
      half = int'(cfg_q.time_width) / 2;
      lo_t = int'(cfg_q.time_center) - half;
      hi_t = int'(cfg_q.time_center) + half;
      if (t >= lo_t && t <= hi_t) begin
        add = s.sample_value;
        if (!cfg_q.time_width[0] && (t == lo_t || t == hi_t)) begin
          add = add >> 1;
        end
        sum = 21'(charge_q) + 21'(add);
        charge_q = (sum > 21'(ACC_MAX)) ? ACC_MAX : sum[19:0];
      end
    end
    if (last) begin
      res = (charge_q < cfg_q.max_value) ? charge_q : cfg_q.max_value;
      charge_q = '0;
      if (res > cfg_q.threshold) begin
        den  = cfg_q.max_value - cfg_q.threshold;
        num  = 64'(res - cfg_q.threshold) * 64'(cfg_q.band_scale) * 64'd256;
        mark = (den != '0) ? 16'(num / 64'(den)) : 16'd0;
        px.pixel_row     = s.row_index;
        px.pixel_col     = s.pad_index + s.col_offset;
        px.pad_result    = res;
        px.mark_fraction = mark;
        px.red   = blend_channel(cfg_q.low_color[31:24], cfg_q.high_color[31:24], mark);
        px.green = blend_channel(cfg_q.low_color[23:16], cfg_q.high_color[23:16], mark);
        px.blue  = blend_channel(cfg_q.low_color[15:8], cfg_q.high_color[15:8], mark);
        px.alpha = blend_channel(cfg_q.low_color[7:0], cfg_q.high_color[7:0], mark);
        pending_pixels.push_back(px);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      cfg_q    = CFG_RESET;
      charge_q = '0;
      drained  = 1'b0;
      pending_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_index_e'(cfg_addr_i))
          REG_TIME_CENTER: cfg_q.time_center = cfg_wdata_i[9:0];
          REG_TIME_WIDTH:  cfg_q.time_width  = cfg_wdata_i[9:0];
          REG_SHOW_MAX:    cfg_q.show_max    = cfg_wdata_i[0];
          REG_MAX_VALUE:   cfg_q.max_value   = cfg_wdata_i[19:0];
          REG_THRESHOLD:   cfg_q.threshold   = cfg_wdata_i[19:0];
          REG_BAND_SCALE:  cfg_q.band_scale  = cfg_wdata_i[15:0];
          REG_LOW_COLOR:   cfg_q.low_color   = cfg_wdata_i;
          REG_HIGH_COLOR:  cfg_q.high_color  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = pixel_t'(m_axis_tdata[82:0]);
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel row %0d col %0d result 0x%0h",
                                    got.pixel_row, got.pixel_col, got.pad_result));
        end else begin
          want = pending_pixels.pop_front();
          if (got.pixel_row !== want.pixel_row)
            report_mismatch($sformatf("pixel_row 0x%0h, expected 0x%0h",
                                      got.pixel_row, want.pixel_row));
          if (got.pixel_col !== want.pixel_col)
            report_mismatch($sformatf("pixel_col 0x%0h, expected 0x%0h",
                                      got.pixel_col, want.pixel_col));
          if (got.pad_result !== want.pad_result)
            report_mismatch($sformatf("pad_result 0x%0h, expected 0x%0h",
                                      got.pad_result, want.pad_result));
          if (got.mark_fraction !== want.mark_fraction)
            report_mismatch($sformatf("mark_fraction 0x%0h, expected 0x%0h",
                                      got.mark_fraction, want.mark_fraction));
          if (got.red !== want.red)
            report_mismatch($sformatf("red 0x%0h, expected 0x%0h", got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("green 0x%0h, expected 0x%0h", got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("blue 0x%0h, expected 0x%0h", got.blue, want.blue));
          if (got.alpha !== want.alpha)
            report_mismatch($sformatf("alpha 0x%0h, expected 0x%0h", got.alpha, want.alpha));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        integrate_sample(sample_t'(s_axis_tdata[42:0]), s_axis_tlast);
      end
      if (drain_i && !drained) begin
        drained = 1'b1;
        foreach (pending_pixels[i]) begin
          report_mismatch($sformatf("missing pixel row %0d col %0d result 0x%0h",
                                    pending_pixels[i].pixel_row, pending_pixels[i].pixel_col,
                                    pending_pixels[i].pad_result));
        end
      end
    end
    fail_count_o <= errors;
    pending_o    <= pending_pixels.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the charge window colorizer: directed pads at the
// field extremes and window corner cases, then random pads over a series of
// register settings with bursty input, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  import pcwc_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 64;
  localparam int CYCLE_LIMIT    = 900000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 100;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES    = 600;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic        drain;
  logic        hold_req;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;
  int          win_lo;
  int          win_hi;

  always #HALF_PERIOD clk = ~clk;

  pad_charge_window_colorizer_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pcwc_pixel_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .drain_i       (drain),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic sample_t pack_sample(input int t, input int pad, input int val,
                                          input int row, input int col);
    sample_t s;
    s.time_bin     = 10'(t);
    s.pad_index    = 8'(pad);
    s.sample_value = 10'(val);
    s.row_index    = 7'(row);
    s.col_offset   = 8'(col);
    return s;
  endfunction

  // Offer one sample, inserting a random gap between bursts
  task automatic send_sample(input sample_t s, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else gap = ($urandom_range(0, 9) == 0) ? 25 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, s};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering, wait for every pixel, then let the back end go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic program_setting(input int center, input int width, input bit keep_max,
                                 input logic [19:0] max_value, input logic [19:0] threshold,
                                 input logic [15:0] band, input logic [31:0] lo_color,
                                 input logic [31:0] hi_color);
    write_reg(REG_TIME_CENTER, 32'(center));
    write_reg(REG_TIME_WIDTH, 32'(width));
    write_reg(REG_SHOW_MAX, 32'(keep_max));
    write_reg(REG_MAX_VALUE, 32'(max_value));
    write_reg(REG_THRESHOLD, 32'(threshold));
    write_reg(REG_BAND_SCALE, 32'(band));
    write_reg(REG_LOW_COLOR, lo_color);
    write_reg(REG_HIGH_COLOR, hi_color);
    cfg_we <= 1'b0;
    win_lo = center - width / 2;
    win_hi = center + width / 2;
    if (win_lo < 0) win_lo = 0;
    if (win_hi > 1023) win_hi = 1023;
  endtask

  // One pad: mostly in-window bins, some on the borders, some anywhere
  task automatic send_random_pad(output int len);
    int      pick;
    sample_t s;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    s.pad_index  = 8'($urandom);
    s.row_index  = 7'($urandom);
    s.col_offset = 8'($urandom);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) s.time_bin = 10'($urandom);
      else if (pick < 30) s.time_bin = 10'($urandom_range(0, 1) ? win_lo : win_hi);
      else s.time_bin = 10'($urandom_range(win_lo, win_hi));
      pick = $urandom_range(0, 9);
      if (pick == 0) s.sample_value = 10'd0;
      else if (pick == 1) s.sample_value = 10'h3FF;
      else s.sample_value = 10'($urandom);
      send_sample(s, k == len - 1);
    end
  endtask

  initial begin : receiver
    rx_mode_e mode;
    int       seg_left;
    bit       hold_done;
    mode          = RX_ALWAYS;
    seg_left      = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      case (mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  initial begin : stimulus
    int          n;
    int          len;
    int          center;
    int          width;
    logic [19:0] mx;
    logic [19:0] th;
    logic [15:0] band;
    logic [31:0] lo_c;
    logic [31:0] hi_c;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    drain         = 1'b0;
    hold_req      = 1'b0;
    rst_n         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window 495..505 with halved borders, clamp at 128
    send_sample(pack_sample(495, 255, 1023, 127, 255), 1'b1);
    send_sample(pack_sample(505, 0, 7, 0, 0), 1'b0);
    send_sample(pack_sample(500, 0, 0, 0, 0), 1'b1);
    send_sample(pack_sample(494, 1, 1023, 5, 9), 1'b0);
    send_sample(pack_sample(506, 1, 1023, 5, 9), 1'b0);
    send_sample(pack_sample(0, 1, 1023, 5, 9), 1'b0);
    send_sample(pack_sample(1023, 1, 1023, 5, 9), 1'b1);
    send_sample(pack_sample(500, 2, 6, 64, 128), 1'b1);
    send_sample(pack_sample(496, 3, 100, 1, 2), 1'b0);
    send_sample(pack_sample(504, 3, 50, 1, 2), 1'b1);
    settle();

    // window reaching below bin zero
    program_setting(0, 1023, 1'b0, 20'd128, 20'd5, 16'd256, 32'h0, 32'hFFFF_FFFF);
    send_sample(pack_sample(0, 10, 1023, 3, 4), 1'b0);
    send_sample(pack_sample(511, 10, 1, 3, 4), 1'b0);
    send_sample(pack_sample(512, 10, 1000, 3, 4), 1'b1);
    settle();

    // single-bin window at the top, both bounds halved
    program_setting(1023, 0, 1'b0, 20'd128, 20'd5, 16'd256, 32'h0, 32'hFFFF_FFFF);
    send_sample(pack_sample(1023, 20, 1023, 100, 200), 1'b1);
    send_sample(pack_sample(1023, 21, 13, 101, 201), 1'b1);
    send_sample(pack_sample(1022, 22, 1023, 102, 202), 1'b1);
    settle();

    program_setting(500, 10, 1'b1, 20'd128, 20'd5, 16'd256, 32'h0, 32'hFFFF_FFFF);
    send_sample(pack_sample(0, 30, 3, 7, 8), 1'b0);
    send_sample(pack_sample(700, 30, 1023, 7, 8), 1'b0);
    send_sample(pack_sample(5, 30, 5, 7, 8), 1'b1);
    send_sample(pack_sample(100, 31, 0, 7, 8), 1'b1);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) center = 0;
      else if (ph == 1) center = 1023;
      else center = $urandom_range(0, 1023);
      if (ph == 0) width = 1023;
      else if (ph == 1) width = 0;
      else if (ph == 2) width = $urandom_range(0, 1023);
      else width = $urandom_range(0, 24);
      if (ph == 0 || ph == 5) mx = 20'hFFFFF;
      else if (ph == 4) mx = '0;
      else if (ph == 7) mx = 20'($urandom_range(0, 20'hFFFFF));
      else mx = 20'($urandom_range(40, 4000));
      if (ph == 0 || ph == 4 || ph == PRESSURE_PHASE) th = '0;
      else if (ph == 5) th = mx;
      else th = 20'($urandom_range(0, int'(mx) / 2));
      if (ph == 0) band = '0;
      else if (ph == 1) band = 16'hFFFF;
      else band = 16'($urandom);
      if (ph == 0) begin
        lo_c = 32'h0000_0000;
        hi_c = 32'hFFFF_FFFF;
      end else if (ph == 1) begin
        lo_c = 32'hFFFF_FFFF;
        hi_c = 32'h0000_0000;
      end else begin
        lo_c = $urandom;
        hi_c = $urandom;
      end
      program_setting(center, width, (ph % 3) == 2, mx, th, band, lo_c, hi_c);
      if (ph == PRESSURE_PHASE) hold_req <= 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_random_pad(len);
        n += len;
      end
      settle();
    end

    drain <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
